FILE: rtl/asfbt_pkg.sv
// Shared types and constants for the address sorted free block table.
package asfbt_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_COUNT  = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
    } t_entry;

endpackage

FILE: rtl/address_sorted_free_block_table_core.sv
// Free block table kept in ascending address order, one command word at a time.
// One command word is taken when the block is idle and returns one result word. Insert,
// remove, pop, pair count and pair lookup stream the entries through one registered read
// port of the entry RAM, one entry per cycle, while a single write port shifts entries
// up or down; a pop, remove, count or lookup reads every entry held and an insert reads
// the entries from the top down until it finds its place, while commands that need no
// walk skip it. The input is not ready while a command runs. A finished result sits in an
// output register; a command that ends while that register is still full waits for it.
module address_sorted_free_block_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_block_address,
    input  logic [31:0] i_block_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_address,
    output logic [31:0] o_result_length,
    output logic [4:0]  o_pair_count,
    output logic [4:0]  o_entry_count
);

    localparam int AW = asfbt_pkg::ADDR_W;
    localparam int IW = asfbt_pkg::IDX_W;
    localparam int CW = asfbt_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    asfbt_pkg::t_entry r_mem [asfbt_pkg::DEPTH];

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_occ, n_occ;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_left, n_left;
    logic              r_rd_vld, n_rd_vld;
    logic [CW-1:0]     r_rd_pos, n_rd_pos;
    asfbt_pkg::t_entry r_rd_data;
    logic              r_found, n_found;
    asfbt_pkg::t_entry r_prev, n_prev;
    logic              r_have_prev, n_have_prev;
    logic [AW-1:0]     r_pp_addr, n_pp_addr;
    logic              r_have_pp, n_have_pp;
    logic              r_jp, n_jp;
    logic [1:0]        r_status, n_status;
    logic [AW-1:0]     r_res_addr, n_res_addr;
    logic [AW-1:0]     r_res_len, n_res_len;
    logic [CW-1:0]     r_pairs, n_pairs;
    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [31:0]       r_o_addr, n_o_addr;
    logic [31:0]       r_o_len, n_o_len;
    logic [4:0]        r_o_pairs, n_o_pairs;
    logic [4:0]        r_o_count, n_o_count;

    logic              rd_en;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    asfbt_pkg::t_entry wr_data;
    asfbt_pkg::t_entry new_entry;
    logic              w_join;
    logic              w_last;
    logic              w_hit;
    logic              w_f1;
    logic              w_f2;
    logic              w_scan;

    assign new_entry = '{addr: r_addr, len: r_len};
    assign w_join    = (r_rd_data.addr - r_prev.addr) == r_prev.len;
    assign w_last    = r_rd_vld && (r_rd_pos == r_occ - CW'(1));
    assign w_scan    = (r_state == S_INS) || (r_state == S_DEL) ||
                       (r_state == S_CNT) || (r_state == S_FIND);
    assign rd_en     = w_scan && (r_left != '0);

    assign w_hit = (r_cmd == asfbt_pkg::CMD_POP) ? (r_rd_pos == '0)
                                                 : (r_rd_data.addr == r_addr);
    assign w_f1  = !r_found && r_have_prev && (r_prev.addr == r_addr) &&
                   (w_join || (r_have_pp && r_jp));
    assign w_f2  = !r_found && !w_f1 && w_last && r_have_prev && w_join &&
                   (r_rd_data.addr == r_addr);

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_result_address = r_o_addr;
    assign o_result_length  = r_o_len;
    assign o_pair_count     = r_o_pairs;
    assign o_entry_count    = r_o_count;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_len       = r_len;
        n_occ       = r_occ;
        n_found     = r_found;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_pp_addr   = r_pp_addr;
        n_have_pp   = r_have_pp;
        n_jp        = r_jp;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_res_len   = r_res_len;
        n_pairs     = r_pairs;
        n_o_valid   = r_o_valid;
        n_o_status  = r_o_status;
        n_o_addr    = r_o_addr;
        n_o_len     = r_o_len;
        n_o_pairs   = r_o_pairs;
        n_o_count   = r_o_count;
        n_rd_vld    = rd_en;
        n_rd_pos    = r_ptr;
        n_left      = rd_en ? r_left - CW'(1) : r_left;
        if (rd_en) begin
            n_ptr = (r_state == S_INS) ? r_ptr - CW'(1) : r_ptr + CW'(1);
        end else begin
            n_ptr = r_ptr;
        end
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = r_rd_data;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_command;
                    n_addr      = AW'(i_block_address);
                    n_len       = AW'(i_block_length);
                    n_status    = asfbt_pkg::ST_OK;
                    n_res_addr  = '0;
                    n_res_len   = '0;
                    n_pairs     = '0;
                    n_found     = 1'b0;
                    n_have_prev = 1'b0;
                    n_have_pp   = 1'b0;
                    n_ptr       = '0;
                    n_left      = r_occ;
                    n_state     = S_DONE;
                    priority if (i_command == asfbt_pkg::CMD_INSERT) begin
                        if (r_occ == CW'(asfbt_pkg::DEPTH)) begin
                            n_status = asfbt_pkg::ST_FULL;
                        end else if (r_occ == '0) begin
                            wr_en   = 1'b1;
                            wr_idx  = '0;
                            wr_data = '{addr: AW'(i_block_address), len: AW'(i_block_length)};
                            n_occ   = CW'(1);
                        end else begin
                            n_ptr   = r_occ - CW'(1);
                            n_state = S_INS;
                        end
                    end else if (i_command == asfbt_pkg::CMD_POP ||
                                 i_command == asfbt_pkg::CMD_REMOVE ||
                                 i_command == asfbt_pkg::CMD_COUNT ||
                                 i_command == asfbt_pkg::CMD_FIND) begin
                        if (r_occ == '0) begin
                            n_status = asfbt_pkg::ST_EMPTY;
                        end else if (i_command == asfbt_pkg::CMD_COUNT) begin
                            n_state = S_CNT;
                        end else if (i_command == asfbt_pkg::CMD_FIND) begin
                            n_state = S_FIND;
                        end else begin
                            n_state = S_DEL;
                        end
                    end else begin
                        n_status = asfbt_pkg::ST_OK;
                    end
                end
            end
            S_INS: begin
                if (r_rd_vld) begin
                    wr_en  = 1'b1;
                    wr_idx = IW'(r_rd_pos + CW'(1));
                    if (r_rd_data.addr >= r_addr) begin
                        wr_data = r_rd_data;
                        if (r_rd_pos == '0) begin
                            n_state = S_PUT;
                        end
                    end else begin
                        wr_data = new_entry;
                        n_occ   = r_occ + CW'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                wr_data = new_entry;
                n_occ   = r_occ + CW'(1);
                n_state = S_DONE;
            end
            S_DEL: begin
                if (r_rd_vld) begin
                    if (r_found) begin
                        wr_en   = 1'b1;
                        wr_idx  = IW'(r_rd_pos - CW'(1));
                        wr_data = r_rd_data;
                    end else if (w_hit) begin
                        n_found    = 1'b1;
                        n_res_addr = r_rd_data.addr;
                        n_res_len  = r_rd_data.len;
                    end
                    if (w_last) begin
                        if (r_found || w_hit) begin
                            n_occ = r_occ - CW'(1);
                        end else begin
                            n_status = asfbt_pkg::ST_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_CNT: begin
                if (r_rd_vld) begin
                    if (r_have_prev && w_join) begin
                        n_pairs     = r_pairs + CW'(1);
                        n_have_prev = 1'b0;
                    end else begin
                        n_prev      = r_rd_data;
                        n_have_prev = 1'b1;
                    end
                    if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIND: begin
                if (r_rd_vld) begin
                    if (w_f1) begin
                        n_found    = 1'b1;
                        n_res_addr = w_join ? r_prev.addr : r_pp_addr;
                    end else if (w_f2) begin
                        n_found    = 1'b1;
                        n_res_addr = r_prev.addr;
                    end
                    n_pp_addr   = r_prev.addr;
                    n_have_pp   = r_have_prev;
                    n_jp        = r_have_prev && w_join;
                    n_prev      = r_rd_data;
                    n_have_prev = 1'b1;
                    if (w_last) begin
                        if (!(r_found || w_f1 || w_f2)) begin
                            n_status = asfbt_pkg::ST_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_addr   = 32'(r_res_addr);
                    n_o_len    = 32'(r_res_len);
                    n_o_pairs  = 5'(r_pairs);
                    n_o_count  = 5'(r_occ);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_left    <= n_left;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_len       <= n_len;
        r_ptr       <= n_ptr;
        r_rd_pos    <= n_rd_pos;
        r_found     <= n_found;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_pp_addr   <= n_pp_addr;
        r_have_pp   <= n_have_pp;
        r_jp        <= n_jp;
        r_status    <= n_status;
        r_res_addr  <= n_res_addr;
        r_res_len   <= n_res_len;
        r_pairs     <= n_pairs;
        r_o_status  <= n_o_status;
        r_o_addr    <= n_o_addr;
        r_o_len     <= n_o_len;
        r_o_pairs   <= n_o_pairs;
        r_o_count   <= n_o_count;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(asfbt_pkg::DEPTH))
        else $error("occupancy above table depth");

    a_rd_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_ptr < r_occ))
        else $error("read of an entry beyond occupancy");

    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CW'(wr_idx) <= r_occ))
        else $error("write leaves a hole in the table");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !rd_en)
        else $error("table read while idle");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> ($past(r_state) != S_DONE))
        else $error("occupancy changed while delivering a result");

endmodule
